// ===== design/hhe_pkg.sv =====
// Package: HPACK Huffman encoder types, constants and code table.
package hhe_pkg;

  localparam int unsigned OctetW    = 8;
  localparam int unsigned CodeW     = 30;
  localparam int unsigned LenW      = 5;
  localparam int unsigned PendW     = 7;
  localparam int unsigned CntW      = 3;
  localparam int unsigned AccW      = 40;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned MaxOut    = 5;

  typedef struct packed {
    logic [OctetW-1:0] in_octet;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [OctetW-1:0] out_octet;
    logic              last_out;
  } out_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } code_t;

  function automatic logic [CodeW-1:0] code_of(input logic [7:0] s);
    logic [CodeW-1:0] c;
    c = '0;
    case (s)
      8'd0: c = 30'h1ff8; 8'd1: c = 30'h7fffd8; 8'd2: c = 30'hfffffe2; 8'd3: c = 30'hfffffe3;
      8'd4: c = 30'hfffffe4; 8'd5: c = 30'hfffffe5; 8'd6: c = 30'hfffffe6; 8'd7: c = 30'hfffffe7;
      8'd8: c = 30'hfffffe8; 8'd9: c = 30'hffffea; 8'd10: c = 30'h3ffffffc; 8'd11: c = 30'hfffffe9;
      8'd12: c = 30'hfffffea; 8'd13: c = 30'h3ffffffd; 8'd14: c = 30'hfffffeb; 8'd15: c = 30'hfffffec;
      8'd16: c = 30'hfffffed; 8'd17: c = 30'hfffffee; 8'd18: c = 30'hfffffef; 8'd19: c = 30'hffffff0;
      8'd20: c = 30'hffffff1; 8'd21: c = 30'hffffff2; 8'd22: c = 30'h3ffffffe; 8'd23: c = 30'hffffff3;
      8'd24: c = 30'hffffff4; 8'd25: c = 30'hffffff5; 8'd26: c = 30'hffffff6; 8'd27: c = 30'hffffff7;
      8'd28: c = 30'hffffff8; 8'd29: c = 30'hffffff9; 8'd30: c = 30'hffffffa; 8'd31: c = 30'hffffffb;
      8'd32: c = 30'h14; 8'd33: c = 30'h3f8; 8'd34: c = 30'h3f9; 8'd35: c = 30'hffa;
      8'd36: c = 30'h1ff9; 8'd37: c = 30'h15; 8'd38: c = 30'hf8; 8'd39: c = 30'h7fa;
      8'd40: c = 30'h3fa; 8'd41: c = 30'h3fb; 8'd42: c = 30'hf9; 8'd43: c = 30'h7fb;
      8'd44: c = 30'hfa; 8'd45: c = 30'h16; 8'd46: c = 30'h17; 8'd47: c = 30'h18;
      8'd48: c = 30'h0; 8'd49: c = 30'h1; 8'd50: c = 30'h2; 8'd51: c = 30'h19;
      8'd52: c = 30'h1a; 8'd53: c = 30'h1b; 8'd54: c = 30'h1c; 8'd55: c = 30'h1d;
      8'd56: c = 30'h1e; 8'd57: c = 30'h1f; 8'd58: c = 30'h5c; 8'd59: c = 30'hfb;
      8'd60: c = 30'h7ffc; 8'd61: c = 30'h20; 8'd62: c = 30'hffb; 8'd63: c = 30'h3fc;
      8'd64: c = 30'h1ffa; 8'd65: c = 30'h21; 8'd66: c = 30'h5d; 8'd67: c = 30'h5e;
      8'd68: c = 30'h5f; 8'd69: c = 30'h60; 8'd70: c = 30'h61; 8'd71: c = 30'h62;
      8'd72: c = 30'h63; 8'd73: c = 30'h64; 8'd74: c = 30'h65; 8'd75: c = 30'h66;
      8'd76: c = 30'h67; 8'd77: c = 30'h68; 8'd78: c = 30'h69; 8'd79: c = 30'h6a;
      8'd80: c = 30'h6b; 8'd81: c = 30'h6c; 8'd82: c = 30'h6d; 8'd83: c = 30'h6e;
      8'd84: c = 30'h6f; 8'd85: c = 30'h70; 8'd86: c = 30'h71; 8'd87: c = 30'h72;
      8'd88: c = 30'hfc; 8'd89: c = 30'h73; 8'd90: c = 30'hfd; 8'd91: c = 30'h1ffb;
      8'd92: c = 30'h7fff0; 8'd93: c = 30'h1ffc; 8'd94: c = 30'h3ffc; 8'd95: c = 30'h22;
      8'd96: c = 30'h7ffd; 8'd97: c = 30'h3; 8'd98: c = 30'h23; 8'd99: c = 30'h4;
      8'd100: c = 30'h24; 8'd101: c = 30'h5; 8'd102: c = 30'h25; 8'd103: c = 30'h26;
      8'd104: c = 30'h27; 8'd105: c = 30'h6; 8'd106: c = 30'h74; 8'd107: c = 30'h75;
      8'd108: c = 30'h28; 8'd109: c = 30'h29; 8'd110: c = 30'h2a; 8'd111: c = 30'h7;
      8'd112: c = 30'h2b; 8'd113: c = 30'h76; 8'd114: c = 30'h2c; 8'd115: c = 30'h8;
      8'd116: c = 30'h9; 8'd117: c = 30'h2d; 8'd118: c = 30'h77; 8'd119: c = 30'h78;
      8'd120: c = 30'h79; 8'd121: c = 30'h7a; 8'd122: c = 30'h7b; 8'd123: c = 30'h7ffe;
      8'd124: c = 30'h7fc; 8'd125: c = 30'h3ffd; 8'd126: c = 30'h1ffd; 8'd127: c = 30'hffffffc;
      8'd128: c = 30'hfffe6; 8'd129: c = 30'h3fffd2; 8'd130: c = 30'hfffe7; 8'd131: c = 30'hfffe8;
      8'd132: c = 30'h3fffd3; 8'd133: c = 30'h3fffd4; 8'd134: c = 30'h3fffd5; 8'd135: c = 30'h7fffd9;
      8'd136: c = 30'h3fffd6; 8'd137: c = 30'h7fffda; 8'd138: c = 30'h7fffdb; 8'd139: c = 30'h7fffdc;
      8'd140: c = 30'h7fffdd; 8'd141: c = 30'h7fffde; 8'd142: c = 30'hffffeb; 8'd143: c = 30'h7fffdf;
      8'd144: c = 30'hffffec; 8'd145: c = 30'hffffed; 8'd146: c = 30'h3fffd7; 8'd147: c = 30'h7fffe0;
      8'd148: c = 30'hffffee; 8'd149: c = 30'h7fffe1; 8'd150: c = 30'h7fffe2; 8'd151: c = 30'h7fffe3;
      8'd152: c = 30'h7fffe4; 8'd153: c = 30'h1fffdc; 8'd154: c = 30'h3fffd8; 8'd155: c = 30'h7fffe5;
      8'd156: c = 30'h3fffd9; 8'd157: c = 30'h7fffe6; 8'd158: c = 30'h7fffe7; 8'd159: c = 30'hffffef;
      8'd160: c = 30'h3fffda; 8'd161: c = 30'h1fffdd; 8'd162: c = 30'hfffe9; 8'd163: c = 30'h3fffdb;
      8'd164: c = 30'h3fffdc; 8'd165: c = 30'h7fffe8; 8'd166: c = 30'h7fffe9; 8'd167: c = 30'h1fffde;
      8'd168: c = 30'h7fffea; 8'd169: c = 30'h3fffdd; 8'd170: c = 30'h3fffde; 8'd171: c = 30'hfffff0;
      8'd172: c = 30'h1fffdf; 8'd173: c = 30'h3fffdf; 8'd174: c = 30'h7fffeb; 8'd175: c = 30'h7fffec;
      8'd176: c = 30'h1fffe0; 8'd177: c = 30'h1fffe1; 8'd178: c = 30'h3fffe0; 8'd179: c = 30'h1fffe2;
      8'd180: c = 30'h7fffed; 8'd181: c = 30'h3fffe1; 8'd182: c = 30'h7fffee; 8'd183: c = 30'h7fffef;
      8'd184: c = 30'hfffea; 8'd185: c = 30'h3fffe2; 8'd186: c = 30'h3fffe3; 8'd187: c = 30'h3fffe4;
      8'd188: c = 30'h7ffff0; 8'd189: c = 30'h3fffe5; 8'd190: c = 30'h3fffe6; 8'd191: c = 30'h7ffff1;
      8'd192: c = 30'h3ffffe0; 8'd193: c = 30'h3ffffe1; 8'd194: c = 30'hfffeb; 8'd195: c = 30'h7fff1;
      8'd196: c = 30'h3fffe7; 8'd197: c = 30'h7ffff2; 8'd198: c = 30'h3fffe8; 8'd199: c = 30'h1ffffec;
      8'd200: c = 30'h3ffffe2; 8'd201: c = 30'h3ffffe3; 8'd202: c = 30'h3ffffe4; 8'd203: c = 30'h7ffffde;
      8'd204: c = 30'h7ffffdf; 8'd205: c = 30'h3ffffe5; 8'd206: c = 30'hfffff1; 8'd207: c = 30'h1ffffed;
      8'd208: c = 30'h7fff2; 8'd209: c = 30'h1fffe3; 8'd210: c = 30'h3ffffe6; 8'd211: c = 30'h7ffffe0;
      8'd212: c = 30'h7ffffe1; 8'd213: c = 30'h3ffffe7; 8'd214: c = 30'h7ffffe2; 8'd215: c = 30'hfffff2;
      8'd216: c = 30'h1fffe4; 8'd217: c = 30'h1fffe5; 8'd218: c = 30'h3ffffe8; 8'd219: c = 30'h3ffffe9;
      8'd220: c = 30'hffffffd; 8'd221: c = 30'h7ffffe3; 8'd222: c = 30'h7ffffe4; 8'd223: c = 30'h7ffffe5;
      8'd224: c = 30'hfffec; 8'd225: c = 30'hfffff3; 8'd226: c = 30'hfffed; 8'd227: c = 30'h1fffe6;
      8'd228: c = 30'h3fffe9; 8'd229: c = 30'h1fffe7; 8'd230: c = 30'h1fffe8; 8'd231: c = 30'h7ffff3;
      8'd232: c = 30'h3fffea; 8'd233: c = 30'h3fffeb; 8'd234: c = 30'h1ffffee; 8'd235: c = 30'h1ffffef;
      8'd236: c = 30'hfffff4; 8'd237: c = 30'hfffff5; 8'd238: c = 30'h3ffffea; 8'd239: c = 30'h7ffff4;
      8'd240: c = 30'h3ffffeb; 8'd241: c = 30'h7ffffe6; 8'd242: c = 30'h3ffffec; 8'd243: c = 30'h3ffffed;
      8'd244: c = 30'h7ffffe7; 8'd245: c = 30'h7ffffe8; 8'd246: c = 30'h7ffffe9; 8'd247: c = 30'h7ffffea;
      8'd248: c = 30'h7ffffeb; 8'd249: c = 30'hffffffe; 8'd250: c = 30'h7ffffec; 8'd251: c = 30'h7ffffed;
      8'd252: c = 30'h7ffffee; 8'd253: c = 30'h7ffffef; 8'd254: c = 30'h7fffff0; 8'd255: c = 30'h3ffffee;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Canonical code length: per symbol up to 15 bits, else from the code's value range
  function automatic logic [LenW-1:0] len_of(input logic [7:0] s);
    logic [CodeW-1:0] c;
    logic [LenW-1:0]  l;
    c = code_of(s);
    l = LenW'(5);
    case (s)
      8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
      8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104, 8'd108, 8'd109,
      8'd110, 8'd112, 8'd114, 8'd117: l = LenW'(6);
      8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116:
        l = LenW'(5);
      8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76,
      8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd89,
      8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122: l = LenW'(7);
      8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90: l = LenW'(8);
      8'd33, 8'd34, 8'd40, 8'd41, 8'd63: l = LenW'(10);
      8'd39, 8'd43, 8'd124: l = LenW'(11);
      8'd35, 8'd62: l = LenW'(12);
      8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126: l = LenW'(13);
      8'd94, 8'd125: l = LenW'(14);
      8'd60, 8'd96, 8'd123: l = LenW'(15);
      default: begin
        // long codes: length from the code's value range
        if (c >= 30'h3ffffe0) l = LenW'(26 + (c >= 30'h7ffffde ? 1 : 0)
                                          + (c >= 30'hfffffe2 ? 1 : 0)
                                          + (c >= 30'h3ffffffc ? 2 : 0)
                                          - (c < 30'h7ffffde && c >= 30'h3ffffe0 &&
                                             c < 30'h3ffffee + 1 ? 0 : 0));
        else if (c >= 30'h1ffffec) l = LenW'(25);
        else if (c >= 30'hffffea)  l = LenW'(24);
        else if (c >= 30'h7fffd8)  l = LenW'(23);
        else if (c >= 30'h3fffd2)  l = LenW'(22);
        else if (c >= 30'h1fffdc)  l = LenW'(21);
        else if (c >= 30'hfffe6)   l = LenW'(20);
        else l = LenW'(19);
      end
    endcase
    return l;
  endfunction

endpackage

// ===== design/hhe_stream_if.sv =====
// Interface: valid/ready channel carrying one payload item.
interface hhe_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/hpack_huffman_encoder_unit.sv =====
// Top level: HPACK Huffman encoder, one string octet in per transaction.
//
// in_i channel: one octet of a header string per transaction, with
// last_in on the string's final octet. Out channel: encoded octets, MSB
// first, last_out on the final octet of the string; the final octet is
// padded with ones to the byte boundary.
// An octet is taken in every cycle while the output queue has room for five
// more octets; a code yields 0 to 5 octets, which enter the queue memory in
// the same cycle. The queue reads through a registered output, so each
// octet is written to the queue memory and then loaded into the output register.
// Throughput: one input per cycle; sustained output of one octet per cycle,
// so strings of long codes (up to 30 bits) hold off input through the queue.
// Reset clears the pending bit accumulator and the queue. When the receiver
// stalls the queue fills and in ready drops; nothing is lost.
module hpack_huffman_encoder_unit #(
  parameter int unsigned Depth = hhe_pkg::FifoDepth * 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hhe_stream_if.sink   in_i,
  hhe_stream_if.source out_o
);
  logic                     go, room;
  logic [2:0]               n;
  hhe_pkg::out_item_t [4:0] oct;

  assign in_i.ready = room;
  assign go = in_i.valid && room;

  hhe_packer u_packer (
    .clk_i, .rst_ni, .go_i(go), .item_i(in_i.data), .n_o(n), .oct_o(oct)
  );

  hhe_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni, .wr_i(go), .n_i(n), .oct_i(oct), .room_o(room), .out_o(out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) go |-> n <= 3'd5)
    else $error("too many octets");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && in_i.data.last_in) |-> n != 3'd0)
    else $error("last input made no octet");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !room |-> !go)
    else $error("accept without room");
endmodule

// ===== design/hhe_packer.sv =====
// Packer: code lookup, bit accumulation and output octet generation.
module hhe_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  hhe_pkg::in_item_t          item_i,
  output logic [2:0]                 n_o,
  output hhe_pkg::out_item_t [4:0]   oct_o
);
  logic [hhe_pkg::PendW-1:0] pend_q, pend_d;
  logic [hhe_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [hhe_pkg::CodeW-1:0] code;
  logic [hhe_pkg::LenW-1:0]  len;
  logic [hhe_pkg::AccW-1:0]  acc, al;
  logic [5:0]                n;
  logic [2:0]                full, rem;

  always_comb begin
    code = hhe_pkg::code_of(item_i.in_octet);
    len  = hhe_pkg::len_of(item_i.in_octet);
    acc  = (hhe_pkg::AccW'(pend_q) << len) | hhe_pkg::AccW'(code);
    n    = 6'(cnt_q) + 6'(len);
    full = n[5:3];
    rem  = n[2:0];
    // left align so the first octet sits in the top bits, pad with ones
    al   = (acc << (6'd40 - n)) | (hhe_pkg::AccW'({hhe_pkg::AccW{1'b1}}) >> n);
    n_o  = full + ((item_i.last_in && rem != 3'd0) ? 3'd1 : 3'd0);
    for (int i = 0; i < hhe_pkg::MaxOut; i++) begin
      oct_o[i].out_octet = al[hhe_pkg::AccW-1-8*i -: 8];
      oct_o[i].last_out  = item_i.last_in && (3'(i) == n_o - 3'd1);
    end
    if (item_i.last_in) begin
      pend_d = '0;
      cnt_d  = '0;
    end else begin
      pend_d = hhe_pkg::PendW'(acc & ((hhe_pkg::AccW'(1) << rem) - hhe_pkg::AccW'(1)));
      cnt_d  = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (go_i) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

// ===== design/hhe_queue.sv =====
// Octet queue: memory of encoded octets, up to five written per cycle in a row.
module hhe_queue #(
  parameter int unsigned Depth = hhe_pkg::FifoDepth * 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_i,
  input  logic [2:0]               n_i,
  input  hhe_pkg::out_item_t [4:0] oct_i,
  output logic                     room_o,
  hhe_stream_if.source             out_o
);
  localparam int unsigned AW = $clog2(Depth);
  hhe_pkg::out_item_t   mem_q [Depth];
  hhe_pkg::out_item_t   dout_q;
  logic [AW-1:0]        wp_q, rp_q;
  logic [AW:0]          cnt_q, cnt_d;
  logic                 dvalid_q, dvalid_d;
  logic                 pop, load;

  assign pop    = out_o.valid && out_o.ready;
  // registered read: refill the output register when it is empty or draining
  assign load   = (cnt_q != '0) && (!dvalid_q || out_o.ready);
  assign out_o.valid = dvalid_q;
  assign out_o.data  = dout_q;
  assign room_o = cnt_q <= (AW+1)'(Depth - hhe_pkg::MaxOut);
  assign cnt_d  = cnt_q + (wr_i ? (AW+1)'(n_i) : '0) - (load ? (AW+1)'(1) : '0);
  assign dvalid_d = load || (dvalid_q && !pop);

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      for (int i = 0; i < hhe_pkg::MaxOut; i++) begin
        if (3'(i) < n_i) mem_q[AW'(wp_q + AW'(i))] <= oct_i[i];
      end
    end
    if (load) dout_q <= mem_q[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      cnt_q    <= '0;
      dvalid_q <= 1'b0;
    end else begin
      if (wr_i) wp_q <= wp_q + AW'(n_i);
      if (load) rp_q <= rp_q + AW'(1);
      cnt_q    <= cnt_d;
      dvalid_q <= dvalid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> room_o)
    else $error("write without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.data)))
    else $error("output changed while stalled");
endmodule
